@@ sv/priority_queue_with_delete_top_two_top_assert.svh @@
// Assertion macros used by the priority queue RTL.
`ifndef PRIORITY_QUEUE_WITH_DELETE_TOP_TWO_TOP_ASSERT_SVH
`define PRIORITY_QUEUE_WITH_DELETE_TOP_TWO_TOP_ASSERT_SVH

// Check a consequence in the same cycle.
`define PQD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the following cycle.
`define PQD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pqd_pkg.sv @@
// Package with sizes, types and helpers of the priority queue.
package pqd_pkg;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned IN_W        = 32;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned GROUP       = 8;
  localparam int unsigned NGROUP      = (DEPTH + GROUP - 1) / GROUP;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef struct packed {
    logic                   ins;
    logic                   rem;
    logic [VALUE_WIDTH-1:0] value;
  } cmd_t;

  function automatic logic [VALUE_WIDTH-1:0] fit_value(input logic [IN_W-1:0] x);
    logic [VALUE_WIDTH+IN_W-1:0] ext;
    ext = {{VALUE_WIDTH{1'b0}}, x};
    return ext[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [IN_W-1:0] fit_out(input logic [VALUE_WIDTH-1:0] x);
    logic [VALUE_WIDTH+IN_W-1:0] ext;
    ext = {{IN_W{1'b0}}, x};
    return ext[IN_W-1:0];
  endfunction

  function automatic logic [COUNT_OUT_W-1:0] fit_count(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_OUT_W-1:0] ext;
    ext = {{COUNT_OUT_W{1'b0}}, c};
    return ext[COUNT_OUT_W-1:0];
  endfunction

endpackage

@@ sv/pqd_cfg_if.sv @@
// Configuration write channel carrying the order mode word.
interface pqd_cfg_if;
  logic valid;
  logic ready;
  logic order_mode;

  modport source (output valid, output order_mode, input ready);
  modport sink (input valid, input order_mode, output ready);
endinterface

@@ sv/pqd_in_if.sv @@
// Input channel carrying one insert or remove word.
interface pqd_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [pqd_pkg::IN_W-1:0]  value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

@@ sv/pqd_out_if.sv @@
// Output channel carrying one top-two result word.
interface pqd_out_if;
  logic                             valid;
  logic                             ready;
  logic [pqd_pkg::IN_W-1:0]         best;
  logic [pqd_pkg::IN_W-1:0]         second_best;
  logic [pqd_pkg::COUNT_OUT_W-1:0]  entry_count;
  logic [1:0]                       status;

  modport source (output valid, output best, output second_best, output entry_count,
                  output status, input ready);
  modport sink (input valid, input best, input second_best, input entry_count,
                input status, output ready);
endinterface

@@ sv/pqd_cell.sv @@
// One cell of the sorted shift row: holds an entry and shifts with its neighbors.
module pqd_cell (
  input  logic                            clk_i,
  input  pqd_pkg::cmd_t                   cmd_i,
  input  logic                            occ_i,
  input  logic                            tail_i,
  input  logic [pqd_pkg::VALUE_WIDTH-1:0] left_entry_i,
  input  logic                            left_pos_i,
  input  logic [pqd_pkg::VALUE_WIDTH-1:0] right_entry_i,
  output logic [pqd_pkg::VALUE_WIDTH-1:0] entry_o,
  output logic                            pos_o,
  output logic                            eq_o
);

  logic [pqd_pkg::VALUE_WIDTH-1:0] entry_q, entry_d;
  logic                            ge;

  assign pos_o = (occ_i && (entry_q > cmd_i.value)) || tail_i;
  assign ge    = occ_i && (entry_q >= cmd_i.value);
  assign eq_o  = occ_i && (entry_q == cmd_i.value);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (left_pos_i) begin
        entry_d = left_entry_i;
      end else if (pos_o) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.rem && ge) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ sv/priority_queue_with_delete_top_two_top.sv @@
// Top level of the priority queue with delete and top-two readout.
//
// Channels: cfg_i writes order_mode (0 largest on top, 1 smallest on top);
// write it only while no item is in flight. in_i takes one word per item:
// op 0 inserts value, op 1 removes one entry equal to value; value 0 does
// nothing. out_o returns one word per item with best, second_best,
// entry_count and status (0 ok, 1 insert dropped when full, 2 no match).
// Entries sit sorted ascending in a row of DEPTH cells; every cell compares
// against the operand in parallel and shifts with its neighbors, so the
// store updates in the cycle the item is accepted.
// The result is registered in turn in the p1, p2 and output registers; the top
// entries are picked by a two-stage registered OR tree over groups of cells.
// Throughput: one item per cycle while out_o is ready.
// A stalled receiver holds the output word; the tree stages fill up behind
// it and in_i drops ready once the first stage cannot advance.
// Reset empties the store, clears the pipeline and sets order_mode to 0.
module priority_queue_with_delete_top_two_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pqd_cfg_if.sink    cfg_i,
  pqd_in_if.sink     in_i,
  pqd_out_if.source  out_o
);

`include "priority_queue_with_delete_top_two_top_assert.svh"

  logic                            mode_q;
  logic [pqd_pkg::CNT_W-1:0]       count_q, count_d;
  logic [pqd_pkg::DEPTH-1:0]       occ, tail, pos, eq, left_pos, sel1, sel2;
  logic [pqd_pkg::VALUE_WIDTH-1:0] entry       [pqd_pkg::DEPTH];
  logic [pqd_pkg::VALUE_WIDTH-1:0] left_entry  [pqd_pkg::DEPTH];
  logic [pqd_pkg::VALUE_WIDTH-1:0] right_entry [pqd_pkg::DEPTH];
  logic [pqd_pkg::VALUE_WIDTH-1:0] hi1_m       [pqd_pkg::DEPTH];
  logic [pqd_pkg::VALUE_WIDTH-1:0] hi2_m       [pqd_pkg::DEPTH];

  pqd_pkg::cmd_t                   cmd;
  logic [pqd_pkg::VALUE_WIDTH-1:0] v;
  logic                            v_nz, is_rem, full, found, acc;
  pqd_pkg::status_e                st_d;

  logic                            p1_vld_q, p1_adv;
  pqd_pkg::status_e                p1_st_q;

  logic [pqd_pkg::VALUE_WIDTH-1:0] g_hi1_d [pqd_pkg::NGROUP];
  logic [pqd_pkg::VALUE_WIDTH-1:0] g_hi2_d [pqd_pkg::NGROUP];
  logic [pqd_pkg::VALUE_WIDTH-1:0] g_hi1_q [pqd_pkg::NGROUP];
  logic [pqd_pkg::VALUE_WIDTH-1:0] g_hi2_q [pqd_pkg::NGROUP];
  logic [pqd_pkg::VALUE_WIDTH-1:0] lo1_d, lo2_d, lo1_q, lo2_q;
  logic [pqd_pkg::CNT_W-1:0]       p2_cnt_q;
  pqd_pkg::status_e                p2_st_q;
  logic                            p2_vld_q, p2_adv;

  logic [pqd_pkg::VALUE_WIDTH-1:0] hi1_or, hi2_or, best_d, second_d;
  logic                            out_vld_q;
  logic [pqd_pkg::VALUE_WIDTH-1:0] out_best_q, out_second_q;
  logic [pqd_pkg::CNT_W-1:0]       out_cnt_q;
  pqd_pkg::status_e                out_st_q;

  // cell row
  for (genvar i = 0; i < pqd_pkg::DEPTH; i++) begin : g_cell
    assign occ[i]  = pqd_pkg::CNT_W'(i) < count_q;
    assign tail[i] = count_q == pqd_pkg::CNT_W'(i);
    assign sel1[i] = count_q == pqd_pkg::CNT_W'(i + 1);
    assign sel2[i] = count_q == pqd_pkg::CNT_W'(i + 2);
    assign hi1_m[i] = entry[i] & {pqd_pkg::VALUE_WIDTH{sel1[i]}};
    assign hi2_m[i] = entry[i] & {pqd_pkg::VALUE_WIDTH{sel2[i]}};

    if (i == 0) begin : g_first
      assign left_entry[i] = '0;
      assign left_pos[i]   = 1'b0;
    end else begin : g_inner
      assign left_entry[i] = entry[i-1];
      assign left_pos[i]   = pos[i-1];
    end

    if (i == pqd_pkg::DEPTH - 1) begin : g_last
      assign right_entry[i] = '0;
    end else begin : g_body
      assign right_entry[i] = entry[i+1];
    end

    pqd_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_i         (occ[i]),
      .tail_i        (tail[i]),
      .left_entry_i  (left_entry[i]),
      .left_pos_i    (left_pos[i]),
      .right_entry_i (right_entry[i]),
      .entry_o       (entry[i]),
      .pos_o         (pos[i]),
      .eq_o          (eq[i])
    );
  end

  // command decode
  assign v      = pqd_pkg::fit_value(in_i.value);
  assign v_nz   = |v;
  assign is_rem = in_i.op;
  assign full   = count_q == pqd_pkg::CNT_W'(pqd_pkg::DEPTH);
  assign found  = |eq;

  assign p2_adv     = p2_vld_q && (!out_vld_q || out_o.ready);
  assign p1_adv     = p1_vld_q && (!p2_vld_q || p2_adv);
  assign in_i.ready = !p1_vld_q || p1_adv;
  assign acc        = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign cmd.value = v;
  assign cmd.ins   = acc && v_nz && !is_rem && !full;
  assign cmd.rem   = acc && v_nz && is_rem && found;

  always_comb begin
    st_d = pqd_pkg::ST_OK;
    if (v_nz && !is_rem && full) begin
      st_d = pqd_pkg::ST_FULL;
    end else if (v_nz && is_rem && !found) begin
      st_d = pqd_pkg::ST_MISS;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + 1'b1;
    end else if (cmd.rem) begin
      count_d = count_q - 1'b1;
    end
  end

  // first tree stage: group ORs over the masked cells
  always_comb begin
    for (int g = 0; g < int'(pqd_pkg::NGROUP); g++) begin
      g_hi1_d[g] = '0;
      g_hi2_d[g] = '0;
      for (int k = 0; k < int'(pqd_pkg::GROUP); k++) begin
        if (g * int'(pqd_pkg::GROUP) + k < int'(pqd_pkg::DEPTH)) begin
          g_hi1_d[g] = g_hi1_d[g] | hi1_m[g * int'(pqd_pkg::GROUP) + k];
          g_hi2_d[g] = g_hi2_d[g] | hi2_m[g * int'(pqd_pkg::GROUP) + k];
        end
      end
    end
  end

  assign lo1_d = occ[0] ? entry[0] : '0;
  assign lo2_d = occ[1] ? entry[1] : '0;

  // second tree stage: merge groups and select by order
  always_comb begin
    hi1_or = '0;
    hi2_or = '0;
    for (int g = 0; g < int'(pqd_pkg::NGROUP); g++) begin
      hi1_or = hi1_or | g_hi1_q[g];
      hi2_or = hi2_or | g_hi2_q[g];
    end
    best_d   = mode_q ? lo1_q : hi1_or;
    second_d = mode_q ? lo2_q : hi2_or;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      count_q   <= '0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        mode_q <= cfg_i.order_mode;
      end
      count_q <= count_d;
      if (acc) begin
        p1_vld_q <= 1'b1;
      end else if (p1_adv) begin
        p1_vld_q <= 1'b0;
      end
      if (p1_adv) begin
        p2_vld_q <= 1'b1;
      end else if (p2_adv) begin
        p2_vld_q <= 1'b0;
      end
      if (p2_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      p1_st_q <= st_d;
    end
    if (p1_adv) begin
      g_hi1_q  <= g_hi1_d;
      g_hi2_q  <= g_hi2_d;
      lo1_q    <= lo1_d;
      lo2_q    <= lo2_d;
      p2_cnt_q <= count_q;
      p2_st_q  <= p1_st_q;
    end
    if (p2_adv) begin
      out_best_q   <= best_d;
      out_second_q <= second_d;
      out_cnt_q    <= p2_cnt_q;
      out_st_q     <= p2_st_q;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.best        = pqd_pkg::fit_out(out_best_q);
  assign out_o.second_best = pqd_pkg::fit_out(out_second_q);
  assign out_o.entry_count = pqd_pkg::fit_count(out_cnt_q);
  assign out_o.status      = out_st_q;

  `PQD_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= pqd_pkg::CNT_W'(pqd_pkg::DEPTH), "count over depth")
  `PQD_ASSERT_NEXT(a_full_hold, acc && (st_d == pqd_pkg::ST_FULL), $stable(count_q), "full insert changed count")
  `PQD_ASSERT_NEXT(a_rem_dec, cmd.rem, count_q == pqd_pkg::CNT_W'($past(count_q) - 1'b1), "remove did not decrement")
  `PQD_ASSERT_IMPLY(a_empty_out, out_vld_q && (out_cnt_q == '0), (out_best_q == '0) && (out_second_q == '0), "empty result not zero")
  `PQD_ASSERT_IMPLY(a_second_best, out_vld_q && (out_second_q != '0), out_best_q != '0, "second without best")

endmodule

@@ sim/tb_priority_queue_with_delete_top_two_top.sv @@
// Testbench for the priority queue: directed and random insert/remove words checked against a sorted mirror.
`timescale 1ns / 1ps

module tb_priority_queue_with_delete_top_two_top;

  localparam int unsigned IN_W        = pqd_pkg::IN_W;
  localparam int unsigned DEPTH       = pqd_pkg::DEPTH;
  localparam int unsigned COUNT_OUT_W = pqd_pkg::COUNT_OUT_W;

  localparam logic OP_INSERT      = 1'b0;
  localparam logic OP_REMOVE      = 1'b1;
  localparam logic ORDER_LARGEST  = 1'b0;
  localparam logic ORDER_SMALLEST = 1'b1;
  localparam int   LONG_HOLD      = 300;
  localparam int   PHASE_WORDS    = 280;
  localparam int   MAX_REPORTS    = 10;

  typedef struct packed {
    logic            op;
    logic [IN_W-1:0] value;
  } word_t;

  typedef struct packed {
    logic [IN_W-1:0]        best;
    logic [IN_W-1:0]        second_best;
    logic [COUNT_OUT_W-1:0] entry_count;
    pqd_pkg::status_e       status;
  } top_two_t;

  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIX} segment_e;

  localparam word_t DIRECTED[21] = '{
    '{OP_INSERT, 32'h0000_0000}, '{OP_REMOVE, 32'h0000_0000}, '{OP_REMOVE, 32'h0000_0005},
    '{OP_INSERT, 32'hFFFF_FFFF}, '{OP_INSERT, 32'h0000_0001}, '{OP_INSERT, 32'h0000_0001},
    '{OP_INSERT, 32'h8000_0000}, '{OP_INSERT, 32'h7FFF_FFFF}, '{OP_REMOVE, 32'h0000_0001},
    '{OP_REMOVE, 32'h0000_002A}, '{OP_INSERT, 32'hFFFF_FFFF}, '{OP_REMOVE, 32'hFFFF_FFFF},
    '{OP_REMOVE, 32'hFFFF_FFFF}, '{OP_REMOVE, 32'hFFFF_FFFF}, '{OP_INSERT, 32'hAAAA_AAAA},
    '{OP_INSERT, 32'h5555_5555}, '{OP_REMOVE, 32'h8000_0000}, '{OP_REMOVE, 32'h7FFF_FFFF},
    '{OP_REMOVE, 32'h0000_0001}, '{OP_REMOVE, 32'hAAAA_AAAA}, '{OP_REMOVE, 32'h5555_5555}
  };

  class top_two_book;
    logic [IN_W-1:0] sorted_vals[DEPTH];
    int              held;
    logic            smallest_first;
    top_two_t        expected_tops[$];
    int              mismatches;

    function new();
      held           = 0;
      smallest_first = ORDER_LARGEST;
      mismatches     = 0;
    endfunction

    function void set_order(logic mode);
      smallest_first = mode;
    endfunction

    function int pending();
      return expected_tops.size();
    endfunction

    function void note_word(logic op, logic [IN_W-1:0] value);
      top_two_t r;
      int       pos;
      r        = '0;
      r.status = pqd_pkg::ST_OK;
      if (value != '0) begin
        if (op == OP_INSERT) begin
          if (held >= DEPTH) begin
            r.status = pqd_pkg::ST_FULL;
          end else begin
            pos = 0;
            while (pos < held && sorted_vals[pos] <= value) pos++;
            for (int k = held; k > pos; k--) sorted_vals[k] = sorted_vals[k-1];
            sorted_vals[pos] = value;
            held++;
          end
        end else begin
          pos = 0;
          while (pos < held && sorted_vals[pos] != value) pos++;
          if (pos >= held) begin
            r.status = pqd_pkg::ST_MISS;
          end else begin
            for (int k = pos; k + 1 < held; k++) sorted_vals[k] = sorted_vals[k+1];
            held--;
          end
        end
      end
      if (held >= 1) r.best = smallest_first ? sorted_vals[0] : sorted_vals[held-1];
      if (held >= 2) r.second_best = smallest_first ? sorted_vals[1] : sorted_vals[held-2];
      r.entry_count = COUNT_OUT_W'(held);
      expected_tops.push_back(r);
    endfunction

    function void check_word(logic [IN_W-1:0] best, logic [IN_W-1:0] second_best,
                             logic [COUNT_OUT_W-1:0] entry_count, logic [1:0] status);
      top_two_t exp_w;
      if (expected_tops.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result word best=%h second=%h count=%0d status=%0d",
                   $realtime, best, second_best, entry_count, status);
        return;
      end
      exp_w = expected_tops.pop_front();
      if (best !== exp_w.best || second_best !== exp_w.second_best ||
          entry_count !== exp_w.entry_count || status !== exp_w.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: mismatch exp best=%h second=%h count=%0d status=%0d",
                   $realtime, exp_w.best, exp_w.second_best,
                   exp_w.entry_count, exp_w.status);
          $display("%0t: mismatch got best=%h second=%h count=%0d status=%0d",
                   $realtime, best, second_best, entry_count, status);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pqd_cfg_if cfg_ch ();
  pqd_in_if  in_ch ();
  pqd_out_if out_ch ();

  priority_queue_with_delete_top_two_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  top_two_book book = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  logic        long_hold_go;
  logic        long_hold_done = 1'b0;
  int          hold_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) book.set_order(cfg_ch.order_mode);
      if (in_ch.valid && in_ch.ready) book.note_word(in_ch.op, in_ch.value);
      if (out_ch.valid && out_ch.ready)
        book.check_word(out_ch.best, out_ch.second_best, out_ch.entry_count, out_ch.status);
    end
  end

  task automatic write_order(logic mode);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.order_mode <= mode;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic offer_word(logic op, logic [IN_W-1:0] value);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= value;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (book.pending() != 0);
  endtask

  function automatic logic [IN_W-1:0] draw_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return IN_W'($urandom_range(1, 12));
    if (sel < 60) return IN_W'($urandom());
    if (sel < 72) begin
      case ($urandom_range(0, 4))
        0: return 32'hFFFF_FFFF;
        1: return 32'hFFFF_FFFE;
        2: return 32'h8000_0000;
        3: return 32'h7FFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    if (sel < 77) return '0;
    return IN_W'($urandom() >> $urandom_range(1, 31));
  endfunction

  task automatic run_random(int count, bit with_hold);
    segment_e        seg;
    int              seg_left;
    int unsigned     ins_pct;
    logic            op;
    logic [IN_W-1:0] value;
    seg_left = 0;
    ins_pct  = 50;
    for (int i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        seg      = segment_e'($urandom_range(0, 2));
        seg_left = $urandom_range(40, 120);
        case (seg)
          SEG_FILL:  ins_pct = 85;
          SEG_DRAIN: ins_pct = 15;
          default:   ins_pct = 50;
        endcase
      end
      if (with_hold && i == count / 3) long_hold_go <= 1'b1;
      op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
      if (op == OP_REMOVE && book.held > 0 && $urandom_range(0, 99) < 75)
        value = book.sorted_vals[$urandom_range(0, book.held - 1)];
      else
        value = draw_value();
      offer_word(op, value);
      seg_left--;
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.order_mode = ORDER_LARGEST;
    in_ch.valid       = 1'b0;
    in_ch.op          = OP_INSERT;
    in_ch.value       = '0;
    out_ch.ready      = 1'b0;
    long_hold_go      = 1'b0;
    tx_idle_pct       = 19;
    rx_idle_pct       = 69;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_order(ORDER_LARGEST);
    foreach (DIRECTED[i]) offer_word(DIRECTED[i].op, DIRECTED[i].value);
    drain_results();

    for (int p = 0; p < 6; p++) begin
      case (p % 3)
        0: begin tx_idle_pct = 19; rx_idle_pct = 69; end
        1: begin tx_idle_pct = 69; rx_idle_pct = 19; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      write_order((p % 2 == 0) ? ORDER_LARGEST : ORDER_SMALLEST);
      run_random(PHASE_WORDS, p == 2);
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
